@@ rtl/tcf_pkg.sv @@
// shared types and constants of the two-class oldest-first queue block
`default_nettype none

package tcf_pkg;

  localparam int unsigned MODE_W    = 2;
  localparam int unsigned CLASS_W   = 2;
  localparam int unsigned FIELD_W   = 16;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned TAG_MAX_W   = 32;
  localparam int unsigned STAMP_MAX_W = 32;

  localparam logic [MODE_W-1:0] MODE_ENQ     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DEQ_ANY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DEQ_CLS = 2'd2;

  localparam logic CLS_A = 1'b0;
  localparam logic CLS_B = 1'b1;

  typedef enum logic [2:0] {
    OP_ENQ,
    OP_DEQ_ANY,
    OP_DEQ_CLS,
    OP_UNKNOWN,
    OP_NONE
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_STORED    = 3'd0,
    ST_UNKNOWN   = 3'd1,
    ST_FULL      = 3'd2,
    ST_DELIVERED = 3'd3,
    ST_NONE      = 3'd4
  } status_e;

  typedef struct packed {
    op_e                    op;
    logic                   cls;
    logic [TAG_MAX_W-1:0]   tag;
    logic [STAMP_MAX_W-1:0] stamp;
  } cmd_t;

endpackage

`default_nettype wire

@@ rtl/tcf_if.sv @@
// request and response channel interfaces
`default_nettype none

interface tcf_req_if import tcf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [CLASS_W-1:0] item_class;
  logic [FIELD_W-1:0] item_tag;

  modport source (output valid, mode, item_class, item_tag, input ready);
  modport sink   (input valid, mode, item_class, item_tag, output ready);
endinterface

interface tcf_rsp_if import tcf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [FIELD_W-1:0]  out_tag;
  logic                out_class;
  logic [FIELD_W-1:0]  out_stamp;

  modport source (output valid, status, out_tag, out_class, out_stamp, input ready);
  modport sink   (input valid, status, out_tag, out_class, out_stamp, output ready);
endinterface

`default_nettype wire

@@ rtl/two_class_fifo_oldest_first_core.sv @@
// top level of the two-class oldest-first queue block
`default_nettype none

// Two bounded queues, one per class, fed from one request channel and answered on one
// response channel, exactly one response word per request word in request order. Every
// enqueue request takes the next arrival stamp, stored or not; dequeue-any returns the
// older of the two heads by wrap-aware stamp compare. The front end decodes requests and
// stamps them at one word per cycle, while the command queue has room, into a two-entry
// command queue. The back end handles enqueue, unknown-class and unused-mode words straight
// from its idle state; dequeues pass through an execute state that uses the registered read
// of both head entries from the queue memories. Responses leave through a one-word output
// register. The queue memories need no clearing after reset.
module two_class_fifo_oldest_first_core import tcf_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TAG_WIDTH   = 16,
  parameter int unsigned STAMP_WIDTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tcf_req_if.sink    req_i,
  tcf_rsp_if.source  rsp_o
);

  logic fr_valid, fr_ready, bk_valid, bk_ready;
  cmd_t fr_cmd, bk_cmd;

  tcf_front #(
    .TAG_WIDTH   (TAG_WIDTH),
    .STAMP_WIDTH (STAMP_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_valid_o (fr_valid),
    .cmd_ready_i (fr_ready),
    .cmd_o       (fr_cmd)
  );

  tcf_cmd_queue u_cmd_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_i       (fr_cmd),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_o        (bk_cmd)
  );

  tcf_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_WIDTH   (TAG_WIDTH),
    .STAMP_WIDTH (STAMP_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (bk_valid),
    .cmd_ready_o (bk_ready),
    .cmd_i       (bk_cmd),
    .rsp_o       (rsp_o)
  );

endmodule

`default_nettype wire

@@ rtl/tcf_front.sv @@
// front end: request decode and arrival-stamp counter
`default_nettype none

module tcf_front import tcf_pkg::*; #(
  parameter int unsigned TAG_WIDTH   = 16,
  parameter int unsigned STAMP_WIDTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tcf_req_if.sink    req_i,
  output logic       cmd_valid_o,
  input  logic       cmd_ready_i,
  output cmd_t       cmd_o
);

  logic [STAMP_WIDTH-1:0] stamp_q, stamp_d;
  logic                   accept;
  logic [TAG_WIDTH-1:0]   tag;

  assign req_i.ready = cmd_ready_i;
  assign cmd_valid_o = req_i.valid;
  assign accept      = req_i.valid && cmd_ready_i;
  assign tag         = TAG_WIDTH'(req_i.item_tag);

  always_comb begin
    cmd_o.cls   = req_i.item_class[0];
    cmd_o.tag   = TAG_MAX_W'(tag);
    cmd_o.stamp = STAMP_MAX_W'(stamp_q);
    stamp_d     = stamp_q;
    unique case (req_i.mode)
      MODE_ENQ: begin
        cmd_o.op = req_i.item_class[1] ? OP_UNKNOWN : OP_ENQ;
        if (accept) begin
          stamp_d = stamp_q + 1'b1;
        end
      end
      MODE_DEQ_ANY: cmd_o.op = OP_DEQ_ANY;
      MODE_DEQ_CLS: cmd_o.op = req_i.item_class[1] ? OP_UNKNOWN : OP_DEQ_CLS;
      default:      cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stamp_q <= '0;
    end else begin
      stamp_q <= stamp_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/tcf_cmd_queue.sv @@
// two-entry command queue between front and back end
`default_nettype none

module tcf_cmd_queue import tcf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_o
);

  cmd_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign push_ready_o = cnt_q != 2'd2;
  assign pop_valid_o  = cnt_q != 2'd0;
  assign pop_o        = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/tcf_back.sv @@
// back end: class queues, oldest-first selection and response register
`default_nettype none

module tcf_back import tcf_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TAG_WIDTH   = 16,
  parameter int unsigned STAMP_WIDTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  output logic       cmd_ready_o,
  input  cmd_t       cmd_i,
  tcf_rsp_if.source  rsp_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  typedef struct packed {
    logic [TAG_WIDTH-1:0]   tag;
    logic [STAMP_WIDTH-1:0] stamp;
  } entry_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e             state_q;
  cmd_t               cur_q;
  entry_t             mem_a_q [QUEUE_DEPTH];
  entry_t             mem_b_q [QUEUE_DEPTH];
  entry_t             rd_a_q, rd_b_q, wr_entry, pop_entry;
  logic [PTR_W-1:0]   head_a_q, tail_a_q, head_b_q, tail_b_q;
  logic [CNT_W-1:0]   cnt_a_q, cnt_b_q;
  logic               out_valid_q;
  status_e            out_status_q;
  logic [FIELD_W-1:0] out_tag_q, out_stamp_q;
  logic               out_class_q;

  logic                   out_free, take, enq_full, wr_a, wr_b;
  logic                   a_has, b_has, older_a, do_pop, pop_b;
  logic [STAMP_WIDTH-1:0] diff;

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign cmd_ready_o = (state_q == S_IDLE) && out_free;
  assign take        = cmd_valid_i && cmd_ready_o;
  assign enq_full    = cmd_i.cls ? (cnt_b_q == CNT_FULL) : (cnt_a_q == CNT_FULL);
  assign wr_a        = take && (cmd_i.op == OP_ENQ) && !enq_full && (cmd_i.cls == CLS_A);
  assign wr_b        = take && (cmd_i.op == OP_ENQ) && !enq_full && (cmd_i.cls == CLS_B);
  assign wr_entry    = '{tag: TAG_WIDTH'(cmd_i.tag), stamp: STAMP_WIDTH'(cmd_i.stamp)};

  assign a_has   = cnt_a_q != '0;
  assign b_has   = cnt_b_q != '0;
  assign diff    = rd_a_q.stamp - rd_b_q.stamp;
  assign older_a = diff[STAMP_WIDTH-1];

  always_comb begin
    if (cur_q.op == OP_DEQ_CLS) begin
      pop_b  = cur_q.cls;
      do_pop = cur_q.cls ? b_has : a_has;
    end else begin
      pop_b  = !a_has || (b_has && !older_a);
      do_pop = a_has || b_has;
    end
    pop_entry = pop_b ? rd_b_q : rd_a_q;
  end

  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      mem_a_q[tail_a_q] <= wr_entry;
    end
    if (wr_b) begin
      mem_b_q[tail_b_q] <= wr_entry;
    end
    rd_a_q <= mem_a_q[head_a_q];
    rd_b_q <= mem_b_q[head_b_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cur_q        <= '0;
      head_a_q     <= '0;
      tail_a_q     <= '0;
      cnt_a_q      <= '0;
      head_b_q     <= '0;
      tail_b_q     <= '0;
      cnt_b_q      <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_NONE;
      out_tag_q    <= '0;
      out_class_q  <= 1'b0;
      out_stamp_q  <= '0;
    end else begin
      if (out_valid_q && rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (take) begin
            cur_q <= cmd_i;
            out_tag_q   <= '0;
            out_class_q <= 1'b0;
            out_stamp_q <= '0;
            unique case (cmd_i.op)
              OP_ENQ: begin
                out_valid_q <= 1'b1;
                if (enq_full) begin
                  out_status_q <= ST_FULL;
                end else begin
                  out_status_q <= ST_STORED;
                  out_stamp_q  <= FIELD_W'(wr_entry.stamp);
                end
                if (wr_a) begin
                  tail_a_q <= (tail_a_q == PTR_LAST) ? '0 : tail_a_q + 1'b1;
                  cnt_a_q  <= cnt_a_q + 1'b1;
                end
                if (wr_b) begin
                  tail_b_q <= (tail_b_q == PTR_LAST) ? '0 : tail_b_q + 1'b1;
                  cnt_b_q  <= cnt_b_q + 1'b1;
                end
              end
              OP_DEQ_ANY, OP_DEQ_CLS: begin
                state_q <= S_EXEC;
              end
              OP_UNKNOWN: begin
                out_valid_q  <= 1'b1;
                out_status_q <= ST_UNKNOWN;
              end
              default: begin
                out_valid_q  <= 1'b1;
                out_status_q <= ST_NONE;
              end
            endcase
          end
        end
        S_EXEC: begin
          state_q     <= S_IDLE;
          out_valid_q <= 1'b1;
          if (do_pop) begin
            out_status_q <= ST_DELIVERED;
            out_tag_q    <= FIELD_W'(pop_entry.tag);
            out_class_q  <= pop_b;
            out_stamp_q  <= FIELD_W'(pop_entry.stamp);
            if (pop_b) begin
              head_b_q <= (head_b_q == PTR_LAST) ? '0 : head_b_q + 1'b1;
              cnt_b_q  <= cnt_b_q - 1'b1;
            end else begin
              head_a_q <= (head_a_q == PTR_LAST) ? '0 : head_a_q + 1'b1;
              cnt_a_q  <= cnt_a_q - 1'b1;
            end
          end else begin
            out_status_q <= ST_NONE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.status    = out_status_q;
  assign rsp_o.out_tag   = out_tag_q;
  assign rsp_o.out_class = out_class_q;
  assign rsp_o.out_stamp = out_stamp_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_a_q <= CNT_FULL) && (cnt_b_q <= CNT_FULL))
    else $error("queue count above depth");

  a_exec_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |-> !out_valid_q)
    else $error("dequeue executes while response register is occupied");

  a_exec_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |=> (state_q == S_IDLE) && out_valid_q)
    else $error("dequeue did not finish with a response");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) && !a_has && !b_has |=> (out_status_q != ST_DELIVERED))
    else $error("delivered from empty queues");
`endif

endmodule

`default_nettype wire
